>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the weighted H1 orthonormaliser.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define WHGS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition in one cycle implies a property in the next.
`define WHGS_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> hw/rtl/whgs_pkg.sv
// Package of the weighted H1 orthonormaliser: sizes, codes and fixed point helpers.
// Depends on nothing.
package whgs_pkg;

	localparam int MAX_SHAPES = 16;
	localparam int MAX_POINTS = 64;
	localparam int MAX_TRFS   = 8;

	localparam int TW = $clog2(MAX_TRFS);
	localparam int SW = $clog2(MAX_SHAPES);
	localparam int PW = $clog2(MAX_POINTS);
	localparam int AW = TW + SW + PW;
	localparam int STORE_DEPTH = MAX_TRFS * MAX_SHAPES * MAX_POINTS;

	localparam int FRAC   = 20;
	localparam int DW     = 32;
	localparam int QW     = 2 * DW - FRAC;
	localparam int SQ_W   = DW - 1 + FRAC;
	localparam int NRM_W  = (SQ_W + 1) / 2;
	localparam int DVD_W  = DW + FRAC;
	localparam int ACC_W  = QW + PW + 2;
	localparam int TERM_W = QW + 2;

	localparam int NS_W = 5;
	localparam int NP_W = 7;
	localparam int NT_W = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [TW-1:0] IDENT_SLOT = TW'(MAX_TRFS - 1);

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_WEIGHT = 2'd1,
		MODE_RUN    = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_NUM_SHAPES = 2'd0,
		CFG_NUM_POINTS = 2'd1,
		CFG_NUM_TRFS   = 2'd2,
		CFG_UNUSED     = 2'd3
	} cfg_idx_t;

	function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (x > hi) begin
			return DW'(hi);
		end else if (x < lo) begin
			return DW'(lo);
		end
		return DW'(x);
	endfunction

	function automatic logic [AW-1:0] mk_addr(input logic [TW-1:0] t, input logic [SW-1:0] s,
			input logic [PW-1:0] p);
		return {t, s, p};
	endfunction

endpackage

>>> hw/rtl/weighted_h1_gram_schmidt_core.sv
// Top level of the weighted H1 modified Gram-Schmidt orthonormaliser.
// Depends on whgs_pkg and assert_macros.svh.
//
// Use: the input channel (in_valid/in_ready) carries one beat per command: load a sample,
// load a point weight, run the orthonormalisation or read a sample back. Loads give no
// result; a read or a run gives one result beat on out_valid/out_ready, carrying the
// samples read (zero for a run) and the error status with the first shape of zero norm.
// Loads are taken one per cycle while no result is stalled. A read goes through ST_RD_WAIT,
// which copies the samples read into the result register. A run holds in_ready low while
// a small sequencer drives one shared 32x32 multiplier, a bit-serial square root (26 steps)
// and a bit-serial divider (52 steps) over the shapes, points and slots (other transforms
// plus the identity); the divider of the normalisation dominates. Each store has one
// port, so every point costs separate read and write cycles.
// The three sample stores are plain memories with no reset; reading a sample never
// loaded gives an undefined value. Reset clears the error status, loads the default
// register values (16 shapes, 64 points, no other transforms) and drops out_valid.
// While the receiver stalls a result, the result register holds it and no new command
// beat is taken, so nothing is lost or repeated.
// The user writes registers through cfg_wr_en/cfg_index/cfg_wdata only while idle; the block does not enforce this.
`include "assert_macros.svh"

module weighted_h1_gram_schmidt_core
	import whgs_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              mode,
	input  logic [TW-1:0]           trf_index,
	input  logic [SW-1:0]           shape_index,
	input  logic [PW-1:0]           point_index,
	input  logic signed [DW-1:0]    sample_value,
	input  logic signed [DW-1:0]    sample_dx,
	input  logic signed [DW-1:0]    sample_dy,
	input  logic signed [DW-1:0]    point_weight,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [DW-1:0]    out_value,
	output logic signed [DW-1:0]    out_dx,
	output logic signed [DW-1:0]    out_dy,
	output logic                    status,
	output logic [3:0]              bad_shape
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD_WAIT, ST_SH_START,
		ST_IP_RA, ST_IP_RB, ST_IP_CB, ST_IP_MUL, ST_IP_LAST, ST_IP_SAT, ST_IP_MW, ST_IP_ACC,
		ST_IP_END,
		ST_PR_RB, ST_PR_RA, ST_PR_CA, ST_PR_MUL, ST_PR_LAST, ST_PR_WR,
		ST_SQ_STEP,
		ST_NM_RD, ST_NM_CA, ST_DV_INIT, ST_DV_STEP, ST_DV_END, ST_NM_WR
	} state_t;

	state_t state_q;

	// Configuration and error status.
	logic [NS_W-1:0] ns_q;
	logic [NP_W-1:0] np_q;
	logic [NT_W-1:0] nt_q;
	logic [NS_W-1:0] ns_eff;
	logic [NP_W-1:0] np_eff;
	logic [NT_W-1:0] nt_eff;
	logic            err_flag_q;
	logic [3:0]      bad_shape_q;
	logic            out_valid_q;

	// Loop counters: shape i, partner j, slot u, point k, component c, divider step.
	logic [NS_W-1:0] i_q;
	logic [NS_W-1:0] j_q;
	logic [NT_W-1:0] u_q;
	logic [NP_W-1:0] k_q;
	logic [1:0]      c_q;
	logic [5:0]      dv_cnt_q;

	// Datapath.
	logic signed [DW-1:0]     a_q [3];
	logic signed [DW-1:0]     b_q [3];
	logic signed [DW-1:0]     w_q;
	logic signed [DW-1:0]     s_q;
	logic signed [DW-1:0]     p_q;
	logic signed [2*DW-1:0]   prod_q;
	logic signed [TERM_W-1:0] term_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [SQ_W-1:0]          sq_x_q;
	logic [SQ_W-1:0]          sq_r_q;
	logic [SQ_W-1:0]          sq_bit_q;
	logic [NRM_W-1:0]         nrm_q;
	logic [DVD_W-1:0]         dq_q;
	logic [NRM_W-1:0]         rem_q;
	logic                     dv_neg_q;
	logic signed [DW-1:0]     out_value_q;
	logic signed [DW-1:0]     out_dx_q;
	logic signed [DW-1:0]     out_dy_q;

	// Memories and their ports.
	logic signed [DW-1:0] value_mem [STORE_DEPTH];
	logic signed [DW-1:0] dx_mem [STORE_DEPTH];
	logic signed [DW-1:0] dy_mem [STORE_DEPTH];
	logic signed [DW-1:0] weight_mem [MAX_POINTS];
	logic signed [DW-1:0] rd_v_q;
	logic signed [DW-1:0] rd_dx_q;
	logic signed [DW-1:0] rd_dy_q;
	logic signed [DW-1:0] rd_w_q;
	logic [AW-1:0]        mem_addr;
	logic                 mem_we;
	logic signed [DW-1:0] wd_v;
	logic signed [DW-1:0] wd_dx;
	logic signed [DW-1:0] wd_dy;
	logic [PW-1:0]        w_addr;
	logic                 w_we;

	// Combinational helpers.
	logic                   accept_in;
	mode_t                  in_mode;
	logic [TW-1:0]          slot;
	logic [PW-1:0]          kp;
	logic                   np_zero;
	logic                   k_last;
	logic                   u_last;
	logic signed [DW-1:0]   mul_a;
	logic signed [DW-1:0]   mul_b;
	logic signed [QW-1:0]   qprod;
	logic signed [DW-1:0]   proj_new;
	logic signed [DW-1:0]   ip_res;
	logic                   ip_nonpos;
	logic [SQ_W-1:0]        sq_rb;
	logic                   sq_take;
	logic [SQ_W-1:0]        sq_r_nx;
	logic [NRM_W:0]         rem_sh;
	logic                   dv_ge;
	logic [DW-1:0]          a_mag;
	logic signed [DVD_W:0]  dv_signed;
	logic signed [DW-1:0]   div_new;

	assign ns_eff = (ns_q > NS_W'(MAX_SHAPES)) ? NS_W'(MAX_SHAPES) : ns_q;
	assign np_eff = (np_q > NP_W'(MAX_POINTS)) ? NP_W'(MAX_POINTS) : np_q;
	assign nt_eff = (nt_q > NT_W'(MAX_TRFS - 1)) ? NT_W'(MAX_TRFS - 1) : nt_q;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept_in = in_valid && in_ready;
	assign in_mode   = mode_t'(mode);

	// The identity slot is always processed last.
	assign slot    = (u_q == nt_eff) ? IDENT_SLOT : TW'(u_q);
	assign kp      = k_q[PW-1:0];
	assign np_zero = (np_eff == '0);
	assign k_last  = (NP_W'(k_q + 1'b1) >= np_eff);
	assign u_last  = (u_q == nt_eff);

	// Shared multiplier operands; a_q and b_q rotate so that element 0 is always in use.
	always_comb begin
		unique case (state_q)
			ST_IP_MUL: begin
				mul_a = a_q[0];
				mul_b = b_q[0];
			end
			ST_IP_MW: begin
				mul_a = w_q;
				mul_b = s_q;
			end
			ST_PR_MUL: begin
				mul_a = p_q;
				mul_b = b_q[0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Upper bits of the product give the floor of the product scaled down by 2^20.
	assign qprod     = prod_q[2*DW-1:FRAC];
	assign proj_new  = sat32(64'(a_q[0]) - 64'(qprod));
	assign ip_res    = sat32(64'(acc_q));
	assign ip_nonpos = ip_res[DW-1] || (ip_res == '0);

	// Square root, one result bit per step.
	assign sq_rb   = sq_r_q + sq_bit_q;
	assign sq_take = (sq_x_q >= sq_rb);
	assign sq_r_nx = sq_take ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);

	// Restoring division, one quotient bit per step.
	assign rem_sh    = {rem_q, dq_q[DVD_W-1]};
	assign dv_ge     = (rem_sh >= {1'b0, nrm_q});
	assign a_mag     = a_q[0][DW-1] ? DW'(-a_q[0]) : DW'(a_q[0]);
	assign dv_signed = dv_neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
	assign div_new   = sat32(64'(dv_signed));

	// Memory port control.
	always_comb begin
		unique case (state_q)
			ST_IDLE:  mem_addr = mk_addr(trf_index, shape_index, point_index);
			ST_IP_RA: mem_addr = mk_addr(IDENT_SLOT, i_q[SW-1:0], kp);
			ST_IP_RB: mem_addr = mk_addr(IDENT_SLOT, j_q[SW-1:0], kp);
			ST_PR_RB: mem_addr = mk_addr(slot, j_q[SW-1:0], kp);
			default:  mem_addr = mk_addr(slot, i_q[SW-1:0], kp);
		endcase
	end

	assign mem_we = ((state_q == ST_IDLE) && accept_in && (in_mode == MODE_LOAD)) ||
		(state_q == ST_PR_WR) || (state_q == ST_NM_WR);
	assign wd_v   = (state_q == ST_IDLE) ? sample_value : a_q[0];
	assign wd_dx  = (state_q == ST_IDLE) ? sample_dx : a_q[1];
	assign wd_dy  = (state_q == ST_IDLE) ? sample_dy : a_q[2];
	assign w_addr = (state_q == ST_IDLE) ? point_index : kp;
	assign w_we   = (state_q == ST_IDLE) && accept_in && (in_mode == MODE_WEIGHT);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			value_mem[mem_addr] <= wd_v;
		end
		rd_v_q <= value_mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dx_mem[mem_addr] <= wd_dx;
		end
		rd_dx_q <= dx_mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dy_mem[mem_addr] <= wd_dy;
		end
		rd_dy_q <= dy_mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			weight_mem[w_addr] <= point_weight;
		end
		rd_w_q <= weight_mem[w_addr];
	end

	// Sequencer, configuration, error status and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ns_q        <= NS_W'(MAX_SHAPES);
			np_q        <= NP_W'(MAX_POINTS);
			nt_q        <= '0;
			err_flag_q  <= 1'b0;
			bad_shape_q <= '0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			u_q         <= '0;
			k_q         <= '0;
			c_q         <= '0;
			dv_cnt_q    <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_NUM_SHAPES: ns_q <= cfg_wdata[NS_W-1:0];
					CFG_NUM_POINTS: np_q <= cfg_wdata[NP_W-1:0];
					CFG_NUM_TRFS:   nt_q <= cfg_wdata[NT_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						unique case (in_mode)
							MODE_RUN: begin
								err_flag_q  <= 1'b0;
								bad_shape_q <= '0;
								i_q         <= '0;
								j_q         <= '0;
								u_q         <= '0;
								k_q         <= '0;
								state_q     <= ST_SH_START;
							end
							MODE_READ: state_q <= ST_RD_WAIT;
							default: ;
						endcase
					end
				end
				ST_RD_WAIT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_SH_START: begin
					if (i_q == ns_eff) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= np_zero ? ST_IP_END : ST_IP_RA;
					end
				end
				ST_IP_RA: state_q <= ST_IP_RB;
				ST_IP_RB: state_q <= ST_IP_CB;
				ST_IP_CB: begin
					c_q     <= '0;
					state_q <= ST_IP_MUL;
				end
				ST_IP_MUL: begin
					c_q <= c_q + 2'd1;
					if (c_q == 2'd2) begin
						state_q <= ST_IP_LAST;
					end
				end
				ST_IP_LAST: state_q <= ST_IP_SAT;
				ST_IP_SAT:  state_q <= ST_IP_MW;
				ST_IP_MW:   state_q <= ST_IP_ACC;
				ST_IP_ACC: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= ST_IP_END;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_IP_RA;
					end
				end
				ST_IP_END: begin
					if (j_q != i_q) begin
						if (np_zero) begin
							j_q <= j_q + 1'b1;
						end else begin
							u_q     <= '0;
							k_q     <= '0;
							state_q <= ST_PR_RB;
						end
					end else if (ip_nonpos) begin
						// Zero norm: keep the first such shape and leave it unscaled.
						if (!err_flag_q) begin
							err_flag_q  <= 1'b1;
							bad_shape_q <= i_q[3:0];
						end
						i_q     <= i_q + 1'b1;
						j_q     <= '0;
						state_q <= ST_SH_START;
					end else begin
						state_q <= ST_SQ_STEP;
					end
				end
				ST_PR_RB: state_q <= ST_PR_RA;
				ST_PR_RA: state_q <= ST_PR_CA;
				ST_PR_CA: begin
					c_q     <= '0;
					state_q <= ST_PR_MUL;
				end
				ST_PR_MUL: begin
					c_q <= c_q + 2'd1;
					if (c_q == 2'd2) begin
						state_q <= ST_PR_LAST;
					end
				end
				ST_PR_LAST: state_q <= ST_PR_WR;
				ST_PR_WR: begin
					if (!k_last) begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_PR_RB;
					end else begin
						k_q <= '0;
						if (u_last) begin
							u_q     <= '0;
							j_q     <= j_q + 1'b1;
							state_q <= ST_IP_RA;
						end else begin
							u_q     <= u_q + 1'b1;
							state_q <= ST_PR_RB;
						end
					end
				end
				ST_SQ_STEP: begin
					if (sq_bit_q[0]) begin
						u_q     <= '0;
						k_q     <= '0;
						state_q <= ST_NM_RD;
					end
				end
				ST_NM_RD: state_q <= ST_NM_CA;
				ST_NM_CA: begin
					c_q     <= '0;
					state_q <= ST_DV_INIT;
				end
				ST_DV_INIT: begin
					dv_cnt_q <= '0;
					state_q  <= ST_DV_STEP;
				end
				ST_DV_STEP: begin
					dv_cnt_q <= dv_cnt_q + 1'b1;
					if (dv_cnt_q == 6'(DVD_W - 1)) begin
						state_q <= ST_DV_END;
					end
				end
				ST_DV_END: begin
					c_q <= c_q + 2'd1;
					state_q <= (c_q == 2'd2) ? ST_NM_WR : ST_DV_INIT;
				end
				ST_NM_WR: begin
					if (!k_last) begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_NM_RD;
					end else begin
						k_q <= '0;
						if (u_last) begin
							u_q     <= '0;
							i_q     <= i_q + 1'b1;
							j_q     <= '0;
							state_q <= ST_SH_START;
						end else begin
							u_q     <= u_q + 1'b1;
							state_q <= ST_NM_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, steered by the sequencer state.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: acc_q <= '0;
			ST_RD_WAIT: begin
				out_value_q <= rd_v_q;
				out_dx_q    <= rd_dx_q;
				out_dy_q    <= rd_dy_q;
			end
			ST_SH_START: begin
				out_value_q <= '0;
				out_dx_q    <= '0;
				out_dy_q    <= '0;
			end
			ST_IP_RB: begin
				a_q <= '{rd_v_q, rd_dx_q, rd_dy_q};
				w_q <= rd_w_q;
			end
			ST_IP_CB: b_q <= '{rd_v_q, rd_dx_q, rd_dy_q};
			ST_IP_MUL: begin
				term_q <= (c_q == 2'd0) ? '0 : term_q + TERM_W'(qprod);
				a_q    <= '{a_q[1], a_q[2], a_q[0]};
				b_q    <= '{b_q[1], b_q[2], b_q[0]};
			end
			ST_IP_LAST: term_q <= term_q + TERM_W'(qprod);
			ST_IP_SAT:  s_q <= sat32(64'(term_q));
			ST_IP_ACC:  acc_q <= acc_q + ACC_W'(qprod);
			ST_IP_END: begin
				acc_q    <= '0;
				p_q      <= ip_res;
				sq_x_q   <= {ip_res[DW-2:0], {FRAC{1'b0}}};
				sq_r_q   <= '0;
				sq_bit_q <= SQ_W'(1) << (2 * ((SQ_W - 1) / 2));
			end
			ST_PR_RA: b_q <= '{rd_v_q, rd_dx_q, rd_dy_q};
			ST_PR_CA: a_q <= '{rd_v_q, rd_dx_q, rd_dy_q};
			ST_PR_MUL: begin
				b_q <= '{b_q[1], b_q[2], b_q[0]};
				if (c_q != 2'd0) begin
					a_q <= '{a_q[1], a_q[2], proj_new};
				end
			end
			ST_PR_LAST: a_q <= '{a_q[1], a_q[2], proj_new};
			ST_SQ_STEP: begin
				if (sq_take) begin
					sq_x_q <= sq_x_q - sq_rb;
				end
				sq_r_q   <= sq_r_nx;
				sq_bit_q <= sq_bit_q >> 2;
				nrm_q    <= sq_r_nx[NRM_W-1:0];
			end
			ST_NM_CA: a_q <= '{rd_v_q, rd_dx_q, rd_dy_q};
			ST_DV_INIT: begin
				dv_neg_q <= a_q[0][DW-1];
				dq_q     <= {a_mag, {FRAC{1'b0}}};
				rem_q    <= '0;
			end
			ST_DV_STEP: begin
				rem_q <= dv_ge ? NRM_W'(rem_sh - {1'b0, nrm_q}) : rem_sh[NRM_W-1:0];
				dq_q  <= {dq_q[DVD_W-2:0], dv_ge};
			end
			ST_DV_END: a_q <= '{a_q[1], a_q[2], div_new};
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_dx    = out_dx_q;
	assign out_dy    = out_dy_q;
	assign status    = err_flag_q;
	assign bad_shape = bad_shape_q;

	`WHGS_ASSERT_NEXT(a_run_clears_error, accept_in && (in_mode == MODE_RUN), !err_flag_q, "run start did not clear the error status")
	`WHGS_ASSERT(a_busy_no_result, (state_q != ST_IDLE) |-> !out_valid_q, "result shown while the sequencer is busy")
	`WHGS_ASSERT(a_bad_shape_only_on_error, !err_flag_q |-> (bad_shape_q == '0), "bad shape recorded without the error flag")

endmodule
